/* sv/cfslc_pkg.sv */
// Shared types, constants and helpers for the CAN frame to SLCAN text encoder.
// Used by every module of the encoder; depends on nothing else.
package cfslc_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int ID_W           = 29;
    localparam int LEN_W          = 4;
    localparam int DATA_W         = 64;
    localparam int STAMP_W        = 16;
    localparam int CHAR_W         = 8;
    localparam int NIB_W          = 4;
    localparam int CNT_W          = 5;

    localparam logic [CHAR_W-1:0] CR_CHAR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_STD_DATA  = 8'h74;
    localparam logic [CHAR_W-1:0] CH_STD_REM   = 8'h72;
    localparam logic [CHAR_W-1:0] CH_EXT_DATA  = 8'h54;
    localparam logic [CHAR_W-1:0] CH_EXT_REM   = 8'h52;

    typedef enum logic [2:0] {
        KIND_TYPE,
        KIND_ID,
        KIND_LEN,
        KIND_DATA,
        KIND_STAMP,
        KIND_CR
    } char_kind_t;

    typedef struct packed {
        logic       valid;
        char_kind_t kind;
    } seq_step_t;

    typedef struct packed {
        logic shift_id;
        logic shift_data;
        logic shift_stamp;
    } shift_ctl_t;

    typedef struct packed {
        logic [CHAR_W-1:0] type_char;
        logic [NIB_W-1:0]  id_nib;
        logic [NIB_W-1:0]  len_nib;
        logic [NIB_W-1:0]  data_nib;
        logic [NIB_W-1:0]  stamp_nib;
    } frame_view_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-NIB_W){1'b0}}, nib};
        return (nib > 4'd9) ? (wide + 8'h37) : (wide + 8'h30);
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(MAX_DATA_BYTES)) ? LEN_W'(MAX_DATA_BYTES) : len;
    endfunction

endpackage

/* sv/cfslc_shifter.sv */
// Frame holding registers: identifier, data and timestamp nibble shift registers.
// Depends on cfslc_pkg.
module cfslc_shifter
    import cfslc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                extended,
    input  logic                remote,
    input  logic [ID_W-1:0]     identifier,
    input  logic [LEN_W-1:0]    length_code,
    input  logic [DATA_W-1:0]   payload,
    input  logic [STAMP_W-1:0]  stamp,
    input  shift_ctl_t          shift,
    output frame_view_t         view
);

    logic [31:0]        id_sr_reg, id_sr_next;
    logic [DATA_W-1:0]  data_sr_reg, data_sr_next;
    logic [STAMP_W-1:0] stamp_sr_reg, stamp_sr_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CHAR_W-1:0]  type_reg, type_next;
    logic [DATA_W-1:0]  data_swapped;

    always_comb
    begin
        for (int b = 0; b < DATA_W / 8; b++)
        begin
            data_swapped[8*b +: 4]     = payload[8*b+4 +: 4];
            data_swapped[8*b+4 +: 4]   = payload[8*b +: 4];
        end
    end

    always_comb
    begin
        id_sr_next    = id_sr_reg;
        data_sr_next  = data_sr_reg;
        stamp_sr_next = stamp_sr_reg;
        len_next      = len_reg;
        type_next     = type_reg;
        if (load)
        begin
            if (extended)
            begin
                id_sr_next = {3'b000, identifier};
                type_next  = remote ? CH_EXT_REM : CH_EXT_DATA;
            end
            else
            begin
                id_sr_next = {1'b0, identifier[10:0], 20'd0};
                type_next  = remote ? CH_STD_REM : CH_STD_DATA;
            end
            data_sr_next  = data_swapped;
            stamp_sr_next = stamp;
            len_next      = clamp_len(length_code);
        end
        else
        begin
            if (shift.shift_id)
            begin
                id_sr_next = {id_sr_reg[27:0], 4'd0};
            end
            if (shift.shift_data)
            begin
                data_sr_next = {4'd0, data_sr_reg[DATA_W-1:NIB_W]};
            end
            if (shift.shift_stamp)
            begin
                stamp_sr_next = {stamp_sr_reg[STAMP_W-NIB_W-1:0], 4'd0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_sr_reg    <= '0;
            data_sr_reg  <= '0;
            stamp_sr_reg <= '0;
            len_reg      <= '0;
            type_reg     <= '0;
        end
        else
        begin
            id_sr_reg    <= id_sr_next;
            data_sr_reg  <= data_sr_next;
            stamp_sr_reg <= stamp_sr_next;
            len_reg      <= len_next;
            type_reg     <= type_next;
        end
    end

    assign view.type_char = type_reg;
    assign view.id_nib    = id_sr_reg[31:28];
    assign view.len_nib   = len_reg;
    assign view.data_nib  = data_sr_reg[NIB_W-1:0];
    assign view.stamp_nib = stamp_sr_reg[STAMP_W-1:STAMP_W-NIB_W];

endmodule

/* sv/cfslc_sequencer.sv */
// Character sequencer: walks the fields of one SLCAN line, one character per step.
// Depends on cfslc_pkg.
module cfslc_sequencer
    import cfslc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             extended,
    input  logic             remote,
    input  logic [LEN_W-1:0] length_code,
    input  logic             advance,
    output logic             busy,
    output seq_step_t        step,
    output shift_ctl_t       shift
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TYPE,
        ST_ID,
        ST_LEN,
        ST_DATA,
        ST_STAMP,
        ST_CR
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] data_n_reg, data_n_next;
    logic             ext_reg, ext_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        data_n_next = data_n_reg;
        ext_next    = ext_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next  = ST_TYPE;
                    ext_next    = extended;
                    data_n_next = remote ? '0 : {clamp_len(length_code), 1'b0};
                end
            end
            ST_TYPE:
            begin
                if (advance)
                begin
                    state_next = ST_ID;
                    cnt_next   = ext_reg ? CNT_W'(7) : CNT_W'(2);
                end
            end
            ST_ID:
            begin
                if (advance)
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_LEN;
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_LEN:
            begin
                if (advance)
                begin
                    if (data_n_reg == '0)
                    begin
                        state_next = ST_STAMP;
                        cnt_next   = CNT_W'(3);
                    end
                    else
                    begin
                        state_next = ST_DATA;
                        cnt_next   = data_n_reg - 1'b1;
                    end
                end
            end
            ST_DATA:
            begin
                if (advance)
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_STAMP;
                        cnt_next   = CNT_W'(3);
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ST_STAMP:
            begin
                if (advance)
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_CR;
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_CR:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            data_n_reg <= '0;
            ext_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            data_n_reg <= data_n_next;
            ext_reg    <= ext_next;
        end
    end

    always_comb
    begin
        step.valid = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_TYPE:  step.kind = KIND_TYPE;
            ST_ID:    step.kind = KIND_ID;
            ST_LEN:   step.kind = KIND_LEN;
            ST_DATA:  step.kind = KIND_DATA;
            ST_STAMP: step.kind = KIND_STAMP;
            ST_CR:    step.kind = KIND_CR;
            default:  step.kind = KIND_TYPE;
        endcase
    end

    assign busy              = (state_reg != ST_IDLE);
    assign shift.shift_id    = advance && (state_reg == ST_ID);
    assign shift.shift_data  = advance && (state_reg == ST_DATA);
    assign shift.shift_stamp = advance && (state_reg == ST_STAMP);

endmodule

/* sv/cfslc_out_stage.sv */
// Output register: turns the current step into an ASCII character and holds it
// until the receiver takes it. Depends on cfslc_pkg.
module cfslc_out_stage
    import cfslc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  seq_step_t         step,
    input  frame_view_t       view,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] character,
    output logic              last
);

    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              out_free;
    logic [CHAR_W-1:0] composed;

    assign out_free = !valid_reg || !out_stall;
    assign advance  = step.valid && out_free;

    always_comb
    begin
        unique case (step.kind)
            KIND_TYPE:  composed = view.type_char;
            KIND_ID:    composed = hex_char(view.id_nib);
            KIND_LEN:   composed = hex_char(view.len_nib);
            KIND_DATA:  composed = hex_char(view.data_nib);
            KIND_STAMP: composed = hex_char(view.stamp_nib);
            KIND_CR:    composed = CR_CHAR;
            default:    composed = CR_CHAR;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (out_free)
        begin
            valid_next = step.valid;
            char_next  = composed;
            last_next  = (step.kind == KIND_CR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

/* sv/can_frame_to_slcan_ascii.sv */
// Top level of the CAN frame to SLCAN text encoder.
// Depends on cfslc_pkg, cfslc_shifter, cfslc_sequencer and cfslc_out_stage.
//
// The input channel takes one received CAN frame per transaction: frame type
// flags, identifier, length code, eight data bytes and a 16-bit timestamp.
// The output channel returns the SLCAN text line for that frame, one ASCII
// character per transaction, with last set on the closing carriage return.
// A line holds 10 to 31 characters, depending on identifier format, frame
// type and the length code, which is clamped to eight bytes.
// The sequencer state and then the output register lie between acceptance and
// the first character; after that one character is produced per cycle while
// the receiver does not stall. The fields are emitted by nibble shift
// registers stepped by a sequencer, and in_stall stays high until the
// carriage return has left the sequencer.
// A stall on the output holds the character register and freezes the
// sequencer; nothing is lost or repeated.
// Reset clears the sequencer and the output valid flag, so no character is
// pending and the next frame is accepted at once.
module can_frame_to_slcan_ascii
    import cfslc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               extended,
    input  logic               remote,
    input  logic [ID_W-1:0]    identifier,
    input  logic [LEN_W-1:0]   length_code,
    input  logic [DATA_W-1:0]  payload,
    input  logic [STAMP_W-1:0] stamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CHAR_W-1:0]  character,
    output logic               last
);

    logic        busy;
    logic        load;
    logic        advance;
    seq_step_t   step;
    shift_ctl_t  shift;
    frame_view_t view;

    assign in_stall = busy;
    assign load     = in_valid && !busy;

    cfslc_shifter u_shifter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .extended    (extended),
        .remote      (remote),
        .identifier  (identifier),
        .length_code (length_code),
        .payload     (payload),
        .stamp       (stamp),
        .shift       (shift),
        .view        (view)
    );

    cfslc_sequencer u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .extended    (extended),
        .remote      (remote),
        .length_code (length_code),
        .advance     (advance),
        .busy        (busy),
        .step        (step),
        .shift       (shift)
    );

    cfslc_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .view        (view),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .character   (character),
        .last        (last)
    );

endmodule

/* test/can_frame_to_slcan_ascii_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for can_frame_to_slcan_ascii: sends CAN frames and checks the SLCAN text.
// Depends on cfslc_pkg and the encoder RTL; expected characters come from a scoreboard class below.
module can_frame_to_slcan_ascii_tb
    import cfslc_pkg::*;
;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_FRAMES   = 370;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES     = 40;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              tail;
    } line_char_t;

    class slcan_line_scoreboard;
        line_char_t pending_chars[$];
        int         fails = 0;

        function logic [CHAR_W-1:0] ascii_hex(input logic [NIB_W-1:0] nib);
            if (nib < 4'd10)
                return 8'h30 + CHAR_W'(nib);
            else
                return 8'h41 + CHAR_W'(nib - 4'd10);
        endfunction

        function void push_char(input logic [CHAR_W-1:0] code, input logic tail);
            line_char_t c;
            c.code = code;
            c.tail = tail;
            pending_chars.push_back(c);
        endfunction

        // Builds the whole text line of one accepted frame.
        function void note_frame(input logic ext, input logic rtr,
                                 input logic [ID_W-1:0] ident,
                                 input logic [LEN_W-1:0] len_code,
                                 input logic [DATA_W-1:0] data,
                                 input logic [STAMP_W-1:0] ts);
            int               n_bytes;
            logic [7:0]       b;
            n_bytes = (len_code > LEN_W'(MAX_DATA_BYTES)) ? MAX_DATA_BYTES : int'(len_code);
            if (ext)
            begin
                push_char(rtr ? CH_EXT_REM : CH_EXT_DATA, 1'b0);
                push_char(ascii_hex({3'b000, ident[28]}), 1'b0);
                for (int k = 6; k >= 0; k--)
                    push_char(ascii_hex(ident[4*k +: 4]), 1'b0);
            end
            else
            begin
                push_char(rtr ? CH_STD_REM : CH_STD_DATA, 1'b0);
                push_char(ascii_hex({1'b0, ident[10:8]}), 1'b0);
                push_char(ascii_hex(ident[7:4]), 1'b0);
                push_char(ascii_hex(ident[3:0]), 1'b0);
            end
            push_char(ascii_hex(NIB_W'(n_bytes)), 1'b0);
            if (!rtr)
            begin
                for (int k = 0; k < n_bytes; k++)
                begin
                    b = data[8*k +: 8];
                    push_char(ascii_hex(b[7:4]), 1'b0);
                    push_char(ascii_hex(b[3:0]), 1'b0);
                end
            end
            push_char(ascii_hex(ts[15:12]), 1'b0);
            push_char(ascii_hex(ts[11:8]), 1'b0);
            push_char(ascii_hex(ts[7:4]), 1'b0);
            push_char(ascii_hex(ts[3:0]), 1'b0);
            push_char(CR_CHAR, 1'b1);
        endfunction

        function void check_char(input logic [CHAR_W-1:0] got_code, input logic got_tail);
            line_char_t want;
            if (pending_chars.size() == 0)
            begin
                $error("character 0x%02h (last %0b) arrived with nothing expected",
                       got_code, got_tail);
                fails++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (got_code !== want.code)
                begin
                    $error("character: expected 0x%02h, actual 0x%02h", want.code, got_code);
                    fails++;
                end
                if (got_tail !== want.tail)
                begin
                    $error("last: expected %0b, actual %0b", want.tail, got_tail);
                    fails++;
                end
            end
        endfunction

        function int pending_count();
            return pending_chars.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               extended;
    logic               remote;
    logic [ID_W-1:0]    identifier;
    logic [LEN_W-1:0]   length_code;
    logic [DATA_W-1:0]  payload;
    logic [STAMP_W-1:0] stamp;
    logic               out_valid;
    logic               out_stall;
    logic [CHAR_W-1:0]  character;
    logic               last;

    slcan_line_scoreboard sb;
    int                   hold_off_req = 0;
    int                   cycle_count  = 0;

    can_frame_to_slcan_ascii i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .extended    (extended),
        .remote      (remote),
        .identifier  (identifier),
        .length_code (length_code),
        .payload     (payload),
        .stamp       (stamp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .character   (character),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("** can_frame_to_slcan_ascii: FAILED **");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_char(character, last);
    end

    // The receiver picks a new random stall pattern at random intervals and
    // honors requests for one long hold-off.
    initial
    begin
        stall_mode_t stall_mode;
        int          mode_left;
        int          phase;
        int          hold_left;
        int          hold_done;
        out_stall  = 1'b0;
        stall_mode = STALL_NONE;
        mode_left  = 0;
        phase      = 0;
        hold_left  = 0;
        hold_done  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_done != hold_off_req)
            begin
                hold_done = hold_off_req;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(50, 300);
                end
                mode_left--;
                phase++;
                case (stall_mode)
                    STALL_NONE:  out_stall = 1'b0;
                    STALL_LIGHT: out_stall = ($urandom_range(0, 99) < 30);
                    STALL_HEAVY: out_stall = ($urandom_range(0, 99) < 75);
                    default:     out_stall = ((phase % 7) < 3);
                endcase
            end
        end
    end

    task automatic send_frame(input logic ext, input logic rtr,
                              input logic [ID_W-1:0] ident,
                              input logic [LEN_W-1:0] len_code,
                              input logic [DATA_W-1:0] data,
                              input logic [STAMP_W-1:0] ts);
        @(negedge clk);
        in_valid    = 1'b1;
        extended    = ext;
        remote      = rtr;
        identifier  = ident;
        length_code = len_code;
        payload     = data;
        stamp       = ts;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_frame(ext, rtr, ident, len_code, data, ts);
    endtask

    task automatic sender_gap(input int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_line_drain();
        sender_gap(0);
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int                 burst_left;
        logic               ext;
        logic               rtr;
        logic [ID_W-1:0]    ident;
        logic [LEN_W-1:0]   len_code;
        logic [DATA_W-1:0]  data;
        logic [STAMP_W-1:0] ts;
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        extended    = 1'b0;
        remote      = 1'b0;
        identifier  = '0;
        length_code = '0;
        payload     = '0;
        stamp       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_frame(1'b0, 1'b0, '0, 4'd0, '0, '0);
        send_frame(1'b0, 1'b0, 29'h7FF, 4'd8, '1, 16'hFFFF);
        send_frame(1'b0, 1'b1, 29'h5A5, 4'd0, {$urandom, $urandom}, 16'h1234);
        send_frame(1'b0, 1'b1, 29'h123, 4'd15, '1, 16'hABCD);
        send_frame(1'b1, 1'b0, '0, 4'd0, '0, '0);
        send_frame(1'b1, 1'b0, 29'h1FFFFFFF, 4'd8, '1, 16'hFFFF);
        send_frame(1'b1, 1'b1, 29'h1FFFFFFF, 4'd15, '1, 16'h0000);
        send_frame(1'b0, 1'b0, 29'h1FFFFBC9, 4'd2, 64'h0123456789ABCDEF, 16'h0A9F);
        send_frame(1'b1, 1'b0, 29'h10000000, 4'd8, 64'hFEDCBA9876543210, 16'h5E70);
        for (int n = 0; n < 16; n++)
        begin
            send_frame(n[0], 1'b0, ID_W'($urandom), LEN_W'(n), {$urandom, $urandom},
                       STAMP_W'($urandom));
        end
        wait_for_line_drain();

        burst_left = 0;
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n == 120)
                hold_off_req++;
            if (n == 240)
                wait_for_line_drain();
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                if ($urandom_range(0, 2) != 0)
                    sender_gap($urandom_range(1, 40));
            end
            burst_left--;
            ext = 1'($urandom_range(0, 1));
            rtr = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       ident = '0;
                1:       ident = '1;
                2:       ident = ID_W'($urandom_range(0, 12'h7FF));
                default: ident = ID_W'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0)
                len_code = LEN_W'($urandom_range(9, 15));
            else
                len_code = LEN_W'($urandom_range(0, 8));
            data = {$urandom, $urandom};
            ts   = STAMP_W'($urandom);
            send_frame(ext, rtr, ident, len_code, data, ts);
        end

        sender_gap(0);
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.pending_count() == 0)
            $display("** can_frame_to_slcan_ascii: PASSED **");
        else
            $display("** can_frame_to_slcan_ascii: FAILED **");
        $finish;
    end

endmodule
